>>> rtl/core/fdl_pkg.sv
// shared constants and types for the fractional delay line
`default_nettype none
package fdl_pkg;

   // sample store geometry (power of two)
   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);

   // field widths
   localparam int SAMPLE_W = 24;
   localparam int INT_W    = 10;
   localparam int FRAC_W   = 16;
   localparam int DELAY_W  = INT_W + FRAC_W;
   localparam int CMD_W    = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_WRITE       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_LIN   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LINEAR      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_HERMITE     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DEFAULT_RD  = 3'd4;

   // kind of read handed to the interpolator
   typedef enum logic [1:0] {
      MODE_DIRECT,
      MODE_LINEAR,
      MODE_HERMITE
   } mode_type;

   // interpolator control
   typedef struct packed {
      logic     start;
      mode_type mode;
   } interp_ctl_type;

endpackage
`default_nettype wire

>>> rtl/core/fdl_if.sv
// request, response and register-write channels of the fractional delay line
`default_nettype none

interface fdl_req_if;
   import fdl_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           command;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic [DELAY_W-1:0]         delay_amount;

   modport source (output valid, command, sample_in, delay_amount, input ready);
   modport sink   (input valid, command, sample_in, delay_amount, output ready);
endinterface

interface fdl_rsp_if;
   import fdl_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

interface fdl_csr_if;
   import fdl_pkg::*;
   logic             valid;
   logic             ready;
   logic [INT_W-1:0] default_delay;

   modport source (output valid, default_delay, input ready);
   modport sink   (input valid, default_delay, output ready);
endinterface

`default_nettype wire

>>> rtl/core/fdl_interp.sv
// interpolation unit: direct, linear and four-point hermite with one shared multiplier
`default_nettype none
module fdl_interp
   import fdl_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  interp_ctl_type             ctl,
   input  logic signed [SAMPLE_W-1:0] xm1,
   input  logic signed [SAMPLE_W-1:0] x0,
   input  logic signed [SAMPLE_W-1:0] x1,
   input  logic signed [SAMPLE_W-1:0] x2,
   input  logic [FRAC_W-1:0]          frac,
   output logic                       done,
   output logic signed [SAMPLE_W-1:0] result
);

   localparam int MUL_A_W = 30;
   localparam int PROD_W  = MUL_A_W + FRAC_W + 1;
   localparam int RND_W   = PROD_W - FRAC_W;
   localparam int ACC_W   = 32;

   typedef enum logic [2:0] {
      IS_IDLE,
      IS_COEF1,
      IS_COEF2,
      IS_MUL,
      IS_ACC,
      IS_FIN
   } istate_type;

   istate_type                 state_ff;
   mode_type                   mode_ff;
   logic [1:0]                 step_ff;
   logic                       done_ff;
   logic signed [SAMPLE_W-1:0] result_ff;

   logic signed [SAMPLE_W:0]   c_ff;
   logic signed [SAMPLE_W+1:0] v_ff;
   logic signed [SAMPLE_W:0]   e_ff;
   logic signed [SAMPLE_W+4:0] b_ff;
   logic signed [MUL_A_W-1:0]  mul_a_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [MUL_A_W-1:0]  h_ff;

   // saturate to the sample range
   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(8388607);
      lo = -ACC_W'(8388608);
      if (v > hi) begin
         sat24 = SAMPLE_W'(hi);
      end else if (v < lo) begin
         sat24 = SAMPLE_W'(lo);
      end else begin
         sat24 = v[SAMPLE_W-1:0];
      end
   endfunction

   // shared multiplier, fraction taken as a positive operand
   logic signed [PROD_W-1:0] prod_in;
   assign prod_in = mul_a_ff * $signed({1'b0, frac});

   // round half up by 2^16
   logic signed [PROD_W:0] rnd_sum;
   logic signed [RND_W-1:0] rnd_val;
   assign rnd_sum = (PROD_W+1)'(prod_ff) + (PROD_W+1)'(32768);
   assign rnd_val = rnd_sum[PROD_W-1:FRAC_W];

   // first hermite coefficients
   logic signed [SAMPLE_W+1:0] dx01;
   assign dx01 = (SAMPLE_W+2)'(x0) - (SAMPLE_W+2)'(x1);

   // second hermite coefficients: w = c+v, a = w+v+e, b = w+a
   logic signed [SAMPLE_W+4:0] w_val;
   logic signed [SAMPLE_W+4:0] a_val;
   assign w_val = (SAMPLE_W+5)'(c_ff) + (SAMPLE_W+5)'(v_ff);
   assign a_val = w_val + (SAMPLE_W+5)'(v_ff) + (SAMPLE_W+5)'(e_ff);

   // horner accumulate terms
   logic signed [ACC_W-1:0] h_minus_b;
   logic signed [ACC_W-1:0] h_plus_c;
   logic signed [ACC_W-1:0] lin_sum;
   logic signed [ACC_W-1:0] fin_sum;
   logic signed [ACC_W-1:0] fin_val;
   assign h_minus_b = ACC_W'(rnd_val) - ACC_W'(b_ff);
   assign h_plus_c  = ACC_W'(rnd_val) + ACC_W'(c_ff);
   assign lin_sum   = ACC_W'(x0) + ACC_W'(rnd_val);
   assign fin_sum   = ACC_W'(h_ff) + (ACC_W'(x0) <<< 1) + ACC_W'(1);
   assign fin_val   = fin_sum >>> 1;

   // sequencer with registered result and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            IS_IDLE: begin
               if (ctl.start) begin
                  mode_ff <= ctl.mode;
                  step_ff <= 2'd0;
                  unique case (ctl.mode)
                     MODE_DIRECT: begin
                        result_ff <= x0;
                        done_ff   <= 1'b1;
                     end
                     MODE_LINEAR: begin
                        mul_a_ff <= MUL_A_W'(x1) - MUL_A_W'(x0);
                        state_ff <= IS_MUL;
                     end
                     MODE_HERMITE: begin
                        state_ff <= IS_COEF1;
                     end
                     default: begin
                        result_ff <= x0;
                        done_ff   <= 1'b1;
                     end
                  endcase
               end
            end
            IS_COEF1: begin
               c_ff     <= (SAMPLE_W+1)'(x1) - (SAMPLE_W+1)'(xm1);
               v_ff     <= dx01 <<< 1;
               e_ff     <= (SAMPLE_W+1)'(x2) - (SAMPLE_W+1)'(x0);
               state_ff <= IS_COEF2;
            end
            IS_COEF2: begin
               b_ff     <= w_val + a_val;
               mul_a_ff <= MUL_A_W'(a_val);
               state_ff <= IS_MUL;
            end
            IS_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= IS_ACC;
            end
            IS_ACC: begin
               if (mode_ff == MODE_LINEAR) begin
                  result_ff <= sat24(lin_sum);
                  done_ff   <= 1'b1;
                  state_ff  <= IS_IDLE;
               end else begin
                  step_ff <= step_ff + 2'd1;
                  unique case (step_ff)
                     2'd0: begin
                        mul_a_ff <= h_minus_b[MUL_A_W-1:0];
                        state_ff <= IS_MUL;
                     end
                     2'd1: begin
                        mul_a_ff <= h_plus_c[MUL_A_W-1:0];
                        state_ff <= IS_MUL;
                     end
                     default: begin
                        h_ff     <= rnd_val[MUL_A_W-1:0];
                        state_ff <= IS_FIN;
                     end
                  endcase
               end
            end
            IS_FIN: begin
               result_ff <= sat24(fin_val);
               done_ff   <= 1'b1;
               state_ff  <= IS_IDLE;
            end
            default: begin
               state_ff <= IS_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule
`default_nettype wire

>>> rtl/core/fractional_delay_line.sv
// top level of the fractional delay line: sample memory, read sequencer and response register
// One request is handled at a time. A plain write passes through ST_WRITE; a read at
// the default delay reads one tap, a linear read two (after ST_WRITE when it writes
// first) and a Hermite read four. The sample memory has a separate write port and a
// registered read port and gives one tap per cycle; the interpolator's shared
// multiplier takes each Horner step through its multiply and accumulate states. A
// finished result sits in the response register, so the next request is taken while
// it waits; a second result waits until the first is taken. After reset the memory
// is swept to zero, one entry a cycle over all DEPTH (1024) entries, during which no
// request is taken; register writes are taken at any time.
`default_nettype none
module fractional_delay_line
   import fdl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   fdl_req_if.sink   req_ch,
   fdl_rsp_if.source rsp_ch,
   fdl_csr_if.sink   csr_ch
);

   localparam int SUM_W = ((ADDR_W > INT_W) ? ADDR_W : INT_W) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_WAIT,
      ST_START,
      ST_BUSY,
      ST_OUT
   } state_type;

   state_type                  state_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;

   logic [CMD_W-1:0]           cmd_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [DELAY_W-1:0]         delay_ff;
   mode_type                   mode_ff;
   logic [1:0]                 slot_ff;
   logic [1:0]                 last_slot_ff;
   logic [1:0]                 cap_slot_ff;
   logic                       cap_valid_ff;
   logic signed [SAMPLE_W-1:0] taps_ff [4];

   logic [ADDR_W-1:0]          wp_ff;
   logic [INT_W-1:0]           dflt_delay_ff;
   logic                       clr_busy_ff;
   logic [ADDR_W-1:0]          clr_addr_ff;

   logic signed [SAMPLE_W-1:0] mem [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   logic                       req_accept;
   logic                       rsp_free;
   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_waddr;
   logic signed [SAMPLE_W-1:0] mem_wdata;
   logic [INT_W-1:0]           rd_base;
   logic [SUM_W-1:0]           rd_sum;
   logic [ADDR_W-1:0]          rd_addr;

   interp_ctl_type             ictl;
   logic                       idone;
   logic signed [SAMPLE_W-1:0] iresult;

   // handshakes
   assign req_ch.ready  = (state_ff == ST_IDLE) && !clr_busy_ff;
   assign req_accept    = req_ch.valid && req_ch.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = rsp_data_ff;
   assign csr_ch.ready  = 1'b1;

   // default delay register
   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_delay_ff <= INT_W'(1);
      end else if (csr_ch.valid) begin
         dflt_delay_ff <= csr_ch.default_delay;
      end
   end

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // memory write port: sweep or sample store
   assign mem_we    = clr_busy_ff || (state_ff == ST_WRITE);
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : wp_ff;
   assign mem_wdata = clr_busy_ff ? '0 : sample_ff;

   // tap address: pointer + delay + slot - 1, wrapped to the depth
   assign rd_base = (mode_ff == MODE_DIRECT) ? dflt_delay_ff : delay_ff[DELAY_W-1:FRAC_W];
   assign rd_sum  = SUM_W'(wp_ff) + SUM_W'(rd_base) + SUM_W'(slot_ff) - SUM_W'(1);
   assign rd_addr = rd_sum[ADDR_W-1:0];

   // sample memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // write pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else if (state_ff == ST_WRITE) begin
         wp_ff <= wp_ff - 1'b1;
      end
   end

   // tap capture in the cycle after each read
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_valid_ff <= 1'b0;
      end else begin
         cap_valid_ff <= (state_ff == ST_READ);
      end
      cap_slot_ff <= slot_ff;
      if (cap_valid_ff) begin
         taps_ff[cap_slot_ff] <= rd_data_ff;
      end
   end

   // request fields and read slot counter
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff    <= req_ch.command;
         sample_ff <= req_ch.sample_in;
         delay_ff  <= req_ch.delay_amount;
         priority if (req_ch.command == CMD_HERMITE) begin
            mode_ff      <= MODE_HERMITE;
            slot_ff      <= 2'd0;
            last_slot_ff <= 2'd3;
         end else if (req_ch.command == CMD_DEFAULT_RD) begin
            mode_ff      <= MODE_DIRECT;
            slot_ff      <= 2'd1;
            last_slot_ff <= 2'd1;
         end else begin
            mode_ff      <= MODE_LINEAR;
            slot_ff      <= 2'd1;
            last_slot_ff <= 2'd2;
         end
      end else if (state_ff == ST_READ) begin
         slot_ff <= slot_ff + 2'd1;
      end
   end

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if ((req_ch.command == CMD_WRITE) || (req_ch.command == CMD_WRITE_LIN)) begin
                     state_ff <= ST_WRITE;
                  end else if ((req_ch.command == CMD_LINEAR)
                               || (req_ch.command == CMD_HERMITE)
                               || (req_ch.command == CMD_DEFAULT_RD)) begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_WRITE: begin
               state_ff <= (cmd_ff == CMD_WRITE) ? ST_IDLE : ST_READ;
            end
            ST_READ: begin
               if (slot_ff == last_slot_ff) begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               state_ff <= ST_START;
            end
            ST_START: begin
               state_ff <= ST_BUSY;
            end
            ST_BUSY: begin
               if (idone) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= iresult;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // interpolator
   assign ictl = {(state_ff == ST_START), mode_ff};

   fdl_interp u_interp (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ictl),
      .xm1    (taps_ff[0]),
      .x0     (taps_ff[1]),
      .x1     (taps_ff[2]),
      .x2     (taps_ff[3]),
      .frac   (delay_ff[FRAC_W-1:0]),
      .done   (idone),
      .result (iresult)
   );

   // interpolator finishes only while the sequencer waits for it
   a_done_in_busy: assert property (@(posedge clock) disable iff (reset)
      idone |-> (state_ff == ST_BUSY))
      else $error("interpolator done outside busy state");

   // no memory write while taps are being read
   a_no_write_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !mem_we)
      else $error("memory write during tap read");

   // no response can be pending while the memory is still being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock)
      clr_busy_ff |-> !rsp_valid_ff)
      else $error("response valid during clearing sweep");

endmodule
`default_nettype wire
